// File: rtl/mfb_pkg.sv
// Package for the monochrome frame store blit and flush unit.
// Holds geometry defaults, opcodes, bus command codes and the glyph font.
// No dependencies.
package mfb_pkg;

    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 64;
    localparam int GLYPH_WIDTH       = 6;
    localparam int GLYPH_HEIGHT      = 8;

    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_SPRITE = 3'd1;
    localparam logic [2:0] OP_BYTE   = 3'd2;
    localparam logic [2:0] OP_CURSOR = 3'd3;
    localparam logic [2:0] OP_GLYPH  = 3'd4;
    localparam logic [2:0] OP_FLUSH  = 3'd5;

    localparam logic [7:0] CMD_PAGE   = 8'hB8;
    localparam logic [7:0] CMD_COLUMN = 8'h40;

    typedef struct packed {
        logic [2:0] opcode;
        logic [6:0] pos_x;
        logic [5:0] pos_y;
        logic [7:0] span_width;
        logic [6:0] span_height;
        logic [7:0] value;
    } req_t;

    typedef struct packed {
        logic       to_second_controller;
        logic       command_flag;
        logic [7:0] bus_byte;
        logic       frame_done;
    } rsp_t;

    // Store access commands from the controller to the datapath.
    typedef struct packed {
        logic        clr_we;    // write zero at clr address
        logic        rmw_rd;    // read for read-modify-write
        logic        rmw_wr;    // write back xor of read data and mask
        logic        flush_rd;  // read for flush data byte
        logic [15:0] addr;
        logic [7:0]  mask;
    } mem_cmd_t;

    function automatic logic [7:0] font_col(input logic [7:0] code, input logic [2:0] col);
        logic [4:0] idx;
        logic [47:0] row;
        idx = 5'(code - 8'd65);
        case (idx)
            5'd0:  row = 48'h7C1211127C00;
            5'd1:  row = 48'h7F4949493600;
            5'd2:  row = 48'h3E4141414100;
            5'd3:  row = 48'h7F4141413E00;
            5'd4:  row = 48'h7F4949494100;
            5'd5:  row = 48'h7F0909090100;
            5'd6:  row = 48'h3E4149497900;
            5'd7:  row = 48'h7F0808087F00;
            5'd8:  row = 48'h00417F410000;
            5'd9:  row = 48'h2041413F0100;
            5'd10: row = 48'h7F0814224100;
            5'd11: row = 48'h7F4040404000;
            5'd12: row = 48'h7F0204027F00;
            5'd13: row = 48'h7F0408107F00;
            5'd14: row = 48'h3E4141413E00;
            5'd15: row = 48'h7F0909090600;
            5'd16: row = 48'h3E4141215E00;
            5'd17: row = 48'h7F0919294600;
            5'd18: row = 48'h464949493100;
            5'd19: row = 48'h01017F010100;
            5'd20: row = 48'h3F4040403F00;
            5'd21: row = 48'h1F2040201F00;
            5'd22: row = 48'h3F407E403F00;
            5'd23: row = 48'h631408146300;
            5'd24: row = 48'h070870080700;
            5'd25: row = 48'h615149454300;
            default: row = 48'h0;
        endcase
        if (code < 8'd65 || code > 8'd90 || col > 3'd5)
            return 8'h00;
        return row[47 - 8 * col -: 8];
    endfunction

endpackage

// File: rtl/mfb_if.sv
// Valid/ready channel interface carrying one payload.
// Depends on nothing; payload type is a parameter.
interface mfb_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/mfb_datapath.sv
// Datapath: pixel store memory with xor read-modify-write and clear writes.
// Depends on mfb_pkg.
module mfb_datapath #(
    parameter int STORE_BYTES = 1024
) (
    input  logic              clk,
    input  mfb_pkg::mem_cmd_t cmd,
    output logic [7:0]        rd_data
);
    localparam int AW = $clog2(STORE_BYTES);

    logic [7:0]    mem [STORE_BYTES];
    logic [AW-1:0] addr_reg;
    logic          wr_ok_reg;
    logic          inb;

    assign inb = cmd.addr < 16'(STORE_BYTES);

    always_ff @(posedge clk)
    begin
        if (cmd.rmw_rd || cmd.flush_rd)
        begin
            rd_data <= inb ? mem[cmd.addr[AW-1:0]] : 8'h00;
        end
        if (cmd.rmw_rd)
        begin
            addr_reg  <= cmd.addr[AW-1:0];
            wr_ok_reg <= inb;
        end
        if (cmd.clr_we && inb)
        begin
            mem[cmd.addr[AW-1:0]] <= 8'h00;
        end
        else if (cmd.rmw_wr && wr_ok_reg)
        begin
            mem[addr_reg] <= rd_data ^ cmd.mask;
        end
    end
endmodule

// File: rtl/mfb_ctrl.sv
// Controller: opcode decode, sprite/cursor/flush state and store sequencing.
// Depends on mfb_pkg and mfb_if.
module mfb_ctrl #(
    parameter int SCREEN_WIDTH  = mfb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = mfb_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    mfb_if.sink               req,
    mfb_if.source             rsp,
    output mfb_pkg::mem_cmd_t cmd,
    input  logic [7:0]        rd_data
);
    localparam int STORE_BYTES = SCREEN_WIDTH * SCREEN_HEIGHT / 8;
    localparam int PAGE_COUNT  = SCREEN_HEIGHT / 8;
    localparam int HALF_WIDTH  = SCREEN_WIDTH / 2;
    localparam int TEXT_COLS   = SCREEN_WIDTH / mfb_pkg::GLYPH_WIDTH;
    localparam int TEXT_ROWS   = SCREEN_HEIGHT / mfb_pkg::GLYPH_HEIGHT;
    localparam int SLOTS       = HALF_WIDTH + 2;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CLEAR = 7'b0000010,
        S_RD    = 7'b0000100,
        S_WR    = 7'b0001000,
        S_FRD   = 7'b0010000,
        S_FOUT  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    logic [15:0] cnt_reg, cnt_next;        // clear address or glyph column
    logic [1:0]  part_reg, part_next;      // sprite: 0 upper, 1 lower
    logic [7:0]  val_reg, val_next;
    logic [15:0] ptr_reg, ptr_next;        // base address of current rmw
    logic        glyph_reg, glyph_next;
    logic [5:0]  ccol_reg, ccol_next;
    logic [3:0]  crow_reg, crow_next;
    logic [15:0] baddr_reg, baddr_next;
    logic [2:0]  bshift_reg, bshift_next;
    logic [7:0]  bspan_reg, bspan_next;
    logic [7:0]  bcol_reg, bcol_next;
    logic [3:0]  bleft_reg, bleft_next;
    logic [3:0]  fpage_reg, fpage_next;
    logic        fhalf_reg, fhalf_next;
    logic [7:0]  fslot_reg, fslot_next;
    mfb_pkg::rsp_t out_reg, out_next;
    logic        ovalid_reg, ovalid_next;
    logic [7:0]  mask;
    logic        fdone;

    assign req.ready = (state_reg == S_IDLE) && !ovalid_reg;
    assign rsp.valid = ovalid_reg;
    assign rsp.data  = out_reg;

    always_comb
    begin
        mask = 8'h00;
        if (glyph_reg)
            mask = mfb_pkg::font_col(val_reg, cnt_reg[2:0]);
        else if (part_reg == 2'd0)
            mask = val_reg << bshift_reg;
        else
            mask = val_reg >> (4'd8 - {1'b0, bshift_reg});
    end

    assign fdone = (32'(fpage_reg) + 1 >= PAGE_COUNT) && fhalf_reg
                   && (32'(fslot_reg) + 1 >= SLOTS);

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg; part_next = part_reg; val_next = val_reg;
        ptr_next = ptr_reg; glyph_next = glyph_reg;
        ccol_next = ccol_reg; crow_next = crow_reg;
        baddr_next = baddr_reg; bshift_next = bshift_reg; bspan_next = bspan_reg;
        bcol_next = bcol_reg; bleft_next = bleft_reg;
        fpage_next = fpage_reg; fhalf_next = fhalf_reg; fslot_next = fslot_reg;
        out_next = out_reg;
        ovalid_next = ovalid_reg && !rsp.ready;
        cmd = '0;
        cmd.mask = mask;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    case (req.data.opcode)
                        mfb_pkg::OP_CLEAR:
                        begin
                            cnt_next = '0;
                            state_next = S_CLEAR;
                        end
                        mfb_pkg::OP_SPRITE:
                        begin
                            baddr_next = 16'(req.data.pos_y[5:3]) * 16'(SCREEN_WIDTH)
                                         + 16'(req.data.pos_x);
                            bshift_next = req.data.pos_y[2:0];
                            bspan_next = req.data.span_width;
                            bcol_next = '0;
                            bleft_next = (req.data.span_width == 8'd0) ? 4'd0
                                         : req.data.span_height[6:3];
                        end
                        mfb_pkg::OP_BYTE:
                        begin
                            if (bleft_reg != 4'd0 && bspan_reg != 8'd0)
                            begin
                                val_next = req.data.value;
                                glyph_next = 1'b0;
                                part_next = 2'd0;
                                ptr_next = baddr_reg;
                                state_next = S_RD;
                                baddr_next = baddr_reg + 16'd1;
                                if (bcol_reg + 8'd1 >= bspan_reg)
                                begin
                                    bcol_next = '0;
                                    bleft_next = bleft_reg - 4'd1;
                                    baddr_next = baddr_reg + 16'd1 + 16'(SCREEN_WIDTH)
                                                 - 16'(bspan_reg);
                                end
                                else
                                    bcol_next = bcol_reg + 8'd1;
                            end
                        end
                        mfb_pkg::OP_CURSOR:
                        begin
                            if (32'(req.data.pos_x) < TEXT_COLS
                                && 32'(req.data.pos_y) < TEXT_ROWS)
                            begin
                                ccol_next = req.data.pos_x[5:0];
                                crow_next = req.data.pos_y[3:0];
                            end
                        end
                        mfb_pkg::OP_GLYPH:
                        begin
                            if (32'(ccol_reg) < TEXT_COLS && 32'(crow_reg) < TEXT_ROWS)
                            begin
                                val_next = req.data.value;
                                glyph_next = 1'b1;
                                cnt_next = '0;
                                ptr_next = 16'(crow_reg) * 16'(SCREEN_WIDTH)
                                           + 16'(ccol_reg) * 16'(mfb_pkg::GLYPH_WIDTH);
                                ccol_next = ccol_reg + 6'd1;
                                state_next = S_RD;
                            end
                        end
                        mfb_pkg::OP_FLUSH:
                        begin
                            out_next.to_second_controller = fhalf_reg;
                            out_next.frame_done = fdone;
                            if (fslot_reg == 8'd0)
                            begin
                                out_next.command_flag = 1'b1;
                                out_next.bus_byte = mfb_pkg::CMD_PAGE | 8'(fpage_reg);
                                state_next = S_OUT;
                            end
                            else if (fslot_reg == 8'd1)
                            begin
                                out_next.command_flag = 1'b1;
                                out_next.bus_byte = mfb_pkg::CMD_COLUMN;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                out_next.command_flag = 1'b0;
                                cmd.flush_rd = 1'b1;
                                cmd.addr = 16'(fpage_reg) * 16'(SCREEN_WIDTH)
                                           + (fhalf_reg ? 16'(HALF_WIDTH) : 16'd0)
                                           + 16'(fslot_reg) - 16'd2;
                                state_next = S_FOUT;
                            end
                            if (32'(fslot_reg) + 1 >= SLOTS)
                            begin
                                fslot_next = '0;
                                fhalf_next = !fhalf_reg;
                                if (fhalf_reg)
                                    fpage_next = (32'(fpage_reg) + 1 >= PAGE_COUNT) ? 4'd0
                                                 : fpage_reg + 4'd1;
                            end
                            else
                                fslot_next = fslot_reg + 8'd1;
                        end
                        default: ;
                    endcase
                end
            end
            S_CLEAR:
            begin
                cmd.clr_we = 1'b1;
                cmd.addr = cnt_reg;
                cnt_next = cnt_reg + 16'd1;
                if (32'(cnt_reg) + 1 >= STORE_BYTES)
                    state_next = S_IDLE;
            end
            S_RD:
            begin
                cmd.rmw_rd = 1'b1;
                cmd.addr = glyph_reg ? ptr_reg + cnt_reg
                         : ptr_reg + ((part_reg != 2'd0) ? 16'(SCREEN_WIDTH) : 16'd0);
                state_next = S_WR;
            end
            S_WR:
            begin
                cmd.rmw_wr = 1'b1;
                state_next = S_IDLE;
                if (glyph_reg)
                begin
                    cnt_next = cnt_reg + 16'd1;
                    if (cnt_reg < 16'(mfb_pkg::GLYPH_WIDTH - 1))
                        state_next = S_RD;
                end
                else if (part_reg == 2'd0 && bshift_reg != 3'd0)
                begin
                    part_next = 2'd1;
                    state_next = S_RD;
                end
            end
            S_FOUT:
            begin
                out_next.bus_byte = rd_data;
                ovalid_next = 1'b1;
                state_next = S_IDLE;
            end
            S_OUT:
            begin
                ovalid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ovalid_reg <= 1'b0;
            ccol_reg <= '0; crow_reg <= '0;
            baddr_reg <= '0; bshift_reg <= '0; bspan_reg <= '0;
            bcol_reg <= '0; bleft_reg <= '0;
            fpage_reg <= '0; fhalf_reg <= 1'b0; fslot_reg <= '0;
            cnt_reg <= '0; part_reg <= '0; glyph_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ovalid_reg <= ovalid_next;
            ccol_reg <= ccol_next; crow_reg <= crow_next;
            baddr_reg <= baddr_next; bshift_reg <= bshift_next; bspan_reg <= bspan_next;
            bcol_reg <= bcol_next; bleft_reg <= bleft_next;
            fpage_reg <= fpage_next; fhalf_reg <= fhalf_next; fslot_reg <= fslot_next;
            cnt_reg <= cnt_next; part_reg <= part_next; glyph_reg <= glyph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        ptr_reg <= ptr_next;
        out_reg <= out_next;
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !req.ready)
        else $error("accept while busy");
    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WR |-> $past(state_reg) == S_RD)
        else $error("write without read");
    a_out_from_flush: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg) == S_FOUT || $past(state_reg) == S_OUT)
        else $error("result without flush");
endmodule

// File: rtl/mono_framebuffer_blit_flush_unit.sv
// Monochrome page-mode frame store with xor sprite/glyph draw and flush.
// Flush result: via S_OUT or S_FOUT, then registered as valid. A sprite byte takes
// one read-modify-write, two if pos_y is not page-aligned; a glyph one per column;
// a clear one write per store byte; all on the single store port, where each rmw
// is an S_RD then an S_WR state. One item at a time. Reset clears control state,
// then a clearing pass zeroes the store before the first transfer is taken.
module mono_framebuffer_blit_flush_unit #(
    parameter int SCREEN_WIDTH  = mfb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = mfb_pkg::SCREEN_HEIGHT_DEF
) (
    input logic   clk,
    input logic   rst_n,
    mfb_if.sink   req,
    mfb_if.source rsp
);
    mfb_pkg::mem_cmd_t cmd;
    logic [7:0]        rd_data;

    mfb_ctrl #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp), .cmd(cmd), .rd_data(rd_data)
    );

    mfb_datapath #(.STORE_BYTES(SCREEN_WIDTH * SCREEN_HEIGHT / 8)) u_dp (
        .clk(clk), .cmd(cmd), .rd_data(rd_data)
    );
endmodule

// File: dv/mfb_checker.sv
// Checker for the monochrome frame store unit: watches both channels.
// Predicts flush writes from its own frame store copy; depends on mfb_pkg.
`timescale 1ns / 1ps
module mfb_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_ready,
    input  mfb_pkg::req_t req_data,
    input  logic          rsp_valid,
    input  logic          rsp_ready,
    input  mfb_pkg::rsp_t rsp_data,
    output int            errors,
    output int            pending
);
    localparam int WIDTH     = mfb_pkg::SCREEN_WIDTH_DEF;
    localparam int HEIGHT    = mfb_pkg::SCREEN_HEIGHT_DEF;
    localparam int BYTES     = WIDTH * HEIGHT / 8;
    localparam int PAGES     = HEIGHT / 8;
    localparam int HALF      = WIDTH / 2;
    localparam int TEXT_COLS = WIDTH / mfb_pkg::GLYPH_WIDTH;
    localparam int TEXT_ROWS = HEIGHT / mfb_pkg::GLYPH_HEIGHT;

    localparam logic [47:0] LETTERS [26] = '{
        48'h7C1211127C00, 48'h7F4949493600, 48'h3E4141414100, 48'h7F4141413E00,
        48'h7F4949494100, 48'h7F0909090100, 48'h3E4149497900, 48'h7F0808087F00,
        48'h00417F410000, 48'h2041413F0100, 48'h7F0814224100, 48'h7F4040404000,
        48'h7F0204027F00, 48'h7F0408107F00, 48'h3E4141413E00, 48'h7F0909090600,
        48'h3E4141215E00, 48'h7F0919294600, 48'h464949493100, 48'h01017F010100,
        48'h3F4040403F00, 48'h1F2040201F00, 48'h3F407E403F00, 48'h631408146300,
        48'h070870080700, 48'h615149454300
    };

    logic [7:0] frame [BYTES];
    int cur_col, cur_row;
    int sp_addr, sp_shift, sp_span, sp_col, sp_pages;
    int fl_page, fl_half, fl_slot;
    int err_count = 0;
    int pend_count = 0;
    mfb_pkg::rsp_t flush_q [$];

    assign errors  = err_count;
    assign pending = pend_count;

    task automatic xor_byte(input int addr, input logic [7:0] bits);
        if (addr < BYTES)
            frame[addr] = frame[addr] ^ bits;
    endtask

    task automatic apply_item(input mfb_pkg::req_t it);
        mfb_pkg::rsp_t w;
        int a;
        logic [15:0] wide;
        case (it.opcode)
            mfb_pkg::OP_CLEAR:
                foreach (frame[i]) frame[i] = 8'h00;
            mfb_pkg::OP_SPRITE:
            begin
                sp_addr  = int'(it.pos_y >> 3) * WIDTH + int'(it.pos_x);
                sp_shift = int'(it.pos_y[2:0]);
                sp_span  = int'(it.span_width);
                sp_col   = 0;
                sp_pages = (it.span_width == 0) ? 0 : int'(it.span_height >> 3);
            end
            mfb_pkg::OP_BYTE:
                if (sp_pages != 0 && sp_span != 0)
                begin
                    wide = {8'h00, it.value} << sp_shift;
                    xor_byte(sp_addr, wide[7:0]);
                    if (sp_shift != 0)
                        xor_byte(sp_addr + WIDTH, wide[15:8]);
                    sp_addr++;
                    sp_col++;
                    if (sp_col >= sp_span)
                    begin
                        sp_col = 0;
                        sp_pages--;
                        sp_addr = sp_addr + WIDTH - sp_span;
                    end
                end
            mfb_pkg::OP_CURSOR:
                if (int'(it.pos_x) < TEXT_COLS && int'(it.pos_y) < TEXT_ROWS)
                begin
                    cur_col = int'(it.pos_x);
                    cur_row = int'(it.pos_y);
                end
            mfb_pkg::OP_GLYPH:
                if (cur_col < TEXT_COLS && cur_row < TEXT_ROWS)
                begin
                    if (it.value >= 8'd65 && it.value <= 8'd90)
                        for (int i = 0; i < mfb_pkg::GLYPH_WIDTH; i++)
                            xor_byte(cur_row * WIDTH + cur_col * mfb_pkg::GLYPH_WIDTH + i,
                                     LETTERS[it.value - 8'd65][47 - 8 * i -: 8]);
                    cur_col++;
                end
            mfb_pkg::OP_FLUSH:
            begin
                w.to_second_controller = fl_half[0];
                if (fl_slot == 0)
                begin
                    w.command_flag = 1'b1;
                    w.bus_byte     = mfb_pkg::CMD_PAGE | 8'(fl_page);
                end
                else if (fl_slot == 1)
                begin
                    w.command_flag = 1'b1;
                    w.bus_byte     = mfb_pkg::CMD_COLUMN;
                end
                else
                begin
                    a = fl_page * WIDTH + fl_half * HALF + fl_slot - 2;
                    w.command_flag = 1'b0;
                    w.bus_byte     = (a < BYTES) ? frame[a] : 8'h00;
                end
                w.frame_done = (fl_page + 1 >= PAGES && fl_half == 1 && fl_slot + 1 >= HALF + 2);
                flush_q.push_back(w);
                fl_slot++;
                if (fl_slot >= HALF + 2)
                begin
                    fl_slot = 0;
                    if (fl_half == 0)
                        fl_half = 1;
                    else
                    begin
                        fl_half = 0;
                        fl_page = (fl_page + 1 >= PAGES) ? 0 : fl_page + 1;
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge clk)
    begin
        mfb_pkg::rsp_t want;
        if (!rst_n)
        begin
            foreach (frame[i]) frame[i] = 8'h00;
            cur_col = 0; cur_row = 0;
            sp_addr = 0; sp_shift = 0; sp_span = 0; sp_col = 0; sp_pages = 0;
            fl_page = 0; fl_half = 0; fl_slot = 0;
            flush_q.delete();
            pend_count = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (flush_q.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected bus write, actual %h", $time, rsp_data);
                end
                else
                begin
                    want = flush_q.pop_front();
                    if (rsp_data.to_second_controller !== want.to_second_controller)
                    begin
                        err_count++;
                        $display("%0t: controller select expected %b actual %b", $time,
                                 want.to_second_controller, rsp_data.to_second_controller);
                    end
                    if (rsp_data.command_flag !== want.command_flag)
                    begin
                        err_count++;
                        $display("%0t: command flag expected %b actual %b", $time,
                                 want.command_flag, rsp_data.command_flag);
                    end
                    if (rsp_data.bus_byte !== want.bus_byte)
                    begin
                        err_count++;
                        $display("%0t: bus byte expected %h actual %h", $time,
                                 want.bus_byte, rsp_data.bus_byte);
                    end
                    if (rsp_data.frame_done !== want.frame_done)
                    begin
                        err_count++;
                        $display("%0t: frame done expected %b actual %b", $time,
                                 want.frame_done, rsp_data.frame_done);
                    end
                end
            end
            if (req_valid && req_ready)
                apply_item(req_data);
            pend_count = flush_q.size();
        end
    end
endmodule

// File: dv/mono_framebuffer_blit_flush_unit_tb.sv
// Testbench top for mono_framebuffer_blit_flush_unit: stimulus and verdict.
// Depends on mfb_pkg, mfb_if, the unit and mfb_checker.
`timescale 1ns / 1ps
module mono_framebuffer_blit_flush_unit_tb;

    localparam int LIMIT = 3000000;

    logic clk;
    logic rst_n;
    int   cycles = 0;
    int   errors;
    int   pending;
    int   send_idle = 0;
    int   recv_stall = 0;

    mfb_if #(.payload_t(mfb_pkg::req_t)) req ();
    mfb_if #(.payload_t(mfb_pkg::rsp_t)) rsp ();

    mono_framebuffer_blit_flush_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    mfb_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req_data  (req.data),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .rsp_data  (rsp.data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= ($urandom_range(99) >= recv_stall);

    task automatic transfer(input logic [2:0] op, input int x, input int y, input int w,
                            input int h, input int v);
        mfb_pkg::req_t it;
        bit   done;
        it.opcode      = op;
        it.pos_x       = 7'(x);
        it.pos_y       = 6'(y);
        it.span_width  = 8'(w);
        it.span_height = 7'(h);
        it.value       = 8'(v);
        if ($urandom_range(99) < send_idle)
        begin
            req.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle);
        end
        req.valid <= 1'b1;
        req.data  <= it;
        done = 0;
        while (!done)
        begin
            @(negedge clk);
            done = req.ready;
            @(posedge clk);
        end
    endtask

    task automatic random_noise();
        transfer(3'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic random_burst();
        int kind, w, pages, n;
        kind = $urandom_range(99);
        if (kind < 30)
        begin
            w     = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(1, 8);
            pages = $urandom_range(1, 3);
            transfer(mfb_pkg::OP_SPRITE, $urandom, $urandom, w,
                     pages * 8 + $urandom_range(7), 0);
            n = w * pages;
            if (n > 30)
                n = 30;
            n = n + $urandom_range(1) - $urandom_range(1);
            repeat (n) transfer(mfb_pkg::OP_BYTE, $urandom, $urandom, $urandom, $urandom,
                                $urandom);
        end
        else if (kind < 42)
        begin
            transfer(mfb_pkg::OP_CURSOR, $urandom_range(22), $urandom_range(8), $urandom,
                     $urandom, 0);
            repeat ($urandom_range(1, 5))
                transfer(mfb_pkg::OP_GLYPH, $urandom, $urandom, $urandom, $urandom,
                         ($urandom_range(3) == 0) ? $urandom : $urandom_range(65, 90));
        end
        else if (kind < 90)
            repeat ($urandom_range(1, 40)) transfer(mfb_pkg::OP_FLUSH, $urandom, $urandom,
                                                   $urandom, $urandom, $urandom);
        else if (kind < 91)
            transfer(mfb_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
        else
            random_noise();
    endtask

    initial
    begin
        int sent;
        req.valid = 1'b0;
        req.data  = '0;
        @(posedge clk iff rst_n);
        @(posedge clk);
        transfer(mfb_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
        transfer(mfb_pkg::OP_SPRITE, 0, 0, 2, 8, 0);
        transfer(mfb_pkg::OP_BYTE, 0, 0, 0, 0, 8'hFF);
        transfer(mfb_pkg::OP_BYTE, 0, 0, 0, 0, 8'hA5);
        transfer(mfb_pkg::OP_BYTE, 0, 0, 0, 0, 8'h3C);
        transfer(mfb_pkg::OP_SPRITE, 5, 3, 1, 16, 0);
        transfer(mfb_pkg::OP_BYTE, 0, 0, 0, 0, 8'h81);
        transfer(mfb_pkg::OP_SPRITE, 127, 63, 128, 64, 0);
        transfer(mfb_pkg::OP_BYTE, 0, 0, 0, 0, 8'hFF);
        transfer(mfb_pkg::OP_SPRITE, 10, 10, 0, 127, 0);
        transfer(mfb_pkg::OP_BYTE, 0, 0, 0, 0, 8'h55);
        transfer(mfb_pkg::OP_SPRITE, 10, 10, 4, 7, 0);
        transfer(mfb_pkg::OP_BYTE, 0, 0, 0, 0, 8'h55);
        transfer(mfb_pkg::OP_CURSOR, 21, 0, 0, 0, 0);
        transfer(mfb_pkg::OP_CURSOR, 0, 8, 0, 0, 0);
        transfer(mfb_pkg::OP_CURSOR, 20, 7, 0, 0, 0);
        transfer(mfb_pkg::OP_GLYPH, 0, 0, 0, 0, 65);
        transfer(mfb_pkg::OP_GLYPH, 0, 0, 0, 0, 90);
        transfer(mfb_pkg::OP_CURSOR, 0, 0, 0, 0, 0);
        transfer(mfb_pkg::OP_GLYPH, 0, 0, 0, 0, 90);
        transfer(mfb_pkg::OP_GLYPH, 0, 0, 0, 0, 64);
        transfer(mfb_pkg::OP_GLYPH, 0, 0, 0, 0, 255);
        transfer(3'd6, 127, 63, 255, 127, 255);
        transfer(3'd7, 0, 0, 0, 0, 0);
        repeat (140) transfer(mfb_pkg::OP_FLUSH, 0, 0, 0, 0, 0);
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle  = (phase == 1) ? 83 : (phase == 3) ? 8 : 0;
            recv_stall = (phase == 2) ? 83 : (phase == 3) ? 8 : 0;
            sent = 0;
            while (sent < 12)
            begin
                random_burst();
                sent++;
            end
        end
        repeat (140) transfer(mfb_pkg::OP_FLUSH, 0, 0, 0, 0, 0);
        req.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (1100) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// File: files.f
rtl/mfb_pkg.sv
rtl/mfb_if.sv
rtl/mfb_datapath.sv
rtl/mfb_ctrl.sv
rtl/mono_framebuffer_blit_flush_unit.sv
dv/mfb_checker.sv
dv/mono_framebuffer_blit_flush_unit_tb.sv
